[hw/rtl/census_transform_3x3_core_assert.svh]
// assertion macros for the census transform core
`ifndef CENSUS_TRANSFORM_3X3_CORE_ASSERT_SVH
`define CENSUS_TRANSFORM_3X3_CORE_ASSERT_SVH

// checked on every edge outside reset
`define CENSUS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("census core assertion failed");

// checked on every edge, reset included
`define CENSUS_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("census core assertion failed");

`endif

[hw/rtl/census_pkg.sv]
`default_nettype none

package census_pkg;

   // field widths
   localparam int PIX_W     = 8;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 12;
   localparam int WID_W     = 11;
   localparam int HGT_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 13;
   localparam int LINE_W    = 2 * PIX_W;

   // frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int WIDTH_MIN  = 3;
   localparam int WIDTH_MAX  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int HEIGHT_MIN = 3;
   localparam int HEIGHT_MAX = 4096;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // line store geometry
   localparam int LINE_DEPTH = WIDTH_MAX;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } pos_type;

   typedef struct packed {
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
   } dims_type;

   typedef struct packed {
      logic             last;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] code;
   } result_type;

   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

   // clamp a written width to the supported range
   function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] w);
      logic [WID_W-1:0] r;
      r = w;
      if (w < WID_W'(WIDTH_MIN)) begin
         r = WID_W'(WIDTH_MIN);
      end else if (w > WID_W'(WIDTH_MAX)) begin
         r = WID_W'(WIDTH_MAX);
      end
      return r;
   endfunction

   // clamp a written height to the supported range
   function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] h);
      logic [HGT_W-1:0] r;
      r = h;
      if (h < HGT_W'(HEIGHT_MIN)) begin
         r = HGT_W'(HEIGHT_MIN);
      end else if (h > HGT_W'(HEIGHT_MAX)) begin
         r = HGT_W'(HEIGHT_MAX);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/census_ram.sv]
`default_nettype none

module census_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port, read returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/census_pos.sv]
`default_nettype none

module census_pos (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [census_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  wire logic [census_pkg::CSR_W-1:0]        csr_wdata,
   input  wire logic                                accept,
   input  wire logic                                frame_start,
   output census_pkg::pos_type                      cur_pos,
   output census_pkg::dims_type                     dims
);

   logic [census_pkg::WID_W-1:0] width_ff;
   logic [census_pkg::HGT_W-1:0] height_ff;
   logic [census_pkg::COL_W-1:0] col_ff, col_in;
   logic [census_pkg::ROW_W-1:0] row_ff, row_in;

   logic [census_pkg::COL_W-1:0] start_col, cur_col;
   logic [census_pkg::ROW_W-1:0] start_row, cur_row;
   logic                         line_wrap;
   logic [census_pkg::HGT_W-1:0] wrap_row;
   logic [census_pkg::WID_W-1:0] col_inc;
   logic [census_pkg::HGT_W-1:0] row_inc;

   // configuration registers, stored already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= census_pkg::WID_W'(census_pkg::WIDTH_RESET);
         height_ff <= census_pkg::HGT_W'(census_pkg::HEIGHT_RESET);
      end else if (csr_we) begin
         if (csr_idx == census_pkg::REG_IMAGE_WIDTH) begin
            width_ff <= census_pkg::clamp_width(csr_wdata[census_pkg::WID_W-1:0]);
         end else begin
            height_ff <= census_pkg::clamp_height(csr_wdata);
         end
      end
   end

   // position of the incoming pixel
   always_comb begin
      start_col = frame_start ? '0 : col_ff;
      start_row = frame_start ? '0 : row_ff;
      line_wrap = {1'b0, start_col} >= width_ff;
      wrap_row  = {1'b0, start_row} + (line_wrap ? 13'd1 : 13'd0);
      cur_col   = line_wrap ? '0 : start_col;
      cur_row   = (wrap_row >= height_ff) ? '0 : wrap_row[census_pkg::ROW_W-1:0];
   end

   // position of the pixel after it
   always_comb begin
      col_inc = {1'b0, cur_col} + 11'd1;
      row_inc = {1'b0, cur_row} + 13'd1;
      if (col_inc >= width_ff) begin
         col_in = '0;
         row_in = (row_inc >= height_ff) ? '0 : row_inc[census_pkg::ROW_W-1:0];
      end else begin
         col_in = col_inc[census_pkg::COL_W-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cur_pos.col = cur_col;
   assign cur_pos.row = cur_row;
   assign dims.width  = width_ff;
   assign dims.height = height_ff;

endmodule

`default_nettype wire

[hw/rtl/census_window.sv]
`default_nettype none

module census_window (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              valid,
   input  wire logic [census_pkg::PIX_W-1:0]      pix,
   input  wire logic [census_pkg::LINE_W-1:0]     entry,
   input  wire census_pkg::pos_type               pos,
   input  wire census_pkg::dims_type              dims,
   output logic      [census_pkg::LINE_W-1:0]     line_wdata,
   output logic                                   emit,
   output census_pkg::result_type                 result
);

   census_pkg::window_type       win_ff, win_in;
   logic [census_pkg::PIX_W-1:0] top_px, mid_px, ctr;

   assign top_px     = entry[census_pkg::LINE_W-1:census_pkg::PIX_W];
   assign mid_px     = entry[census_pkg::PIX_W-1:0];
   assign line_wdata = {mid_px, pix};

   // shift the window one column left, new column on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = top_px;
      win_in[1][2] = mid_px;
      win_in[2][2] = pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (valid) begin
         win_ff <= win_in;
      end
   end

   // eight neighbour compares, top-left in the msb
   assign ctr = win_in[1][1];
   assign result.code = {win_in[0][0] < ctr, win_in[0][1] < ctr, win_in[0][2] < ctr,
                         win_in[1][0] < ctr, win_in[1][2] < ctr,
                         win_in[2][0] < ctr, win_in[2][1] < ctr, win_in[2][2] < ctr};

   // centre position and end of frame
   assign result.row  = pos.row - 12'd1;
   assign result.col  = pos.col - 10'd1;
   assign result.last = ({1'b0, pos.row} == dims.height - 13'd1) &&
                        ({1'b0, pos.col} == dims.width - 11'd1);

   assign emit = valid && (pos.row >= 12'd2) && (pos.col >= 10'd2);

endmodule

`default_nettype wire

[hw/rtl/census_fifo.sv]
`default_nettype none

module census_fifo (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire census_pkg::result_type          wr_data,
   input  wire logic                            rd_en,
   output logic                                 rd_valid,
   output census_pkg::result_type               rd_data,
   output logic [census_pkg::FIFO_CW-1:0]       count
);

   census_pkg::result_type           mem_ff [census_pkg::FIFO_DEPTH];
   logic [census_pkg::FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [census_pkg::FIFO_CW-1:0]   count_ff, count_in;

   // occupancy after this cycle's push and pop
   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 3'd1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

`default_nettype wire

[hw/rtl/census_transform_3x3_core.sv]
// channel | direction | payload
// req     | in        | tdata: pixel_value; tuser: frame_start
// rsp     | out       | tdata: census_code, center_row, center_col; tlast: frame_last
// csr     | in        | idx 0 image_width, idx 1 image_height (write only)
//
// one pixel per clock while req_tready is high; an accepted word passes stage one,
// where its line entry is read, and the result queue, where it waits behind older
// words, before it can leave rsp
// reset clears position, window, queue and the registers (640 x 480); the line
// store is not cleared, each entry that feeds a result is written before it is read
// req_tready keeps queue, stage one and new word within three of the four entries
`default_nettype none

`include "census_transform_3x3_core_assert.svh"

module census_transform_3x3_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,   // [7:0] pixel_value
   input  wire logic                                req_tuser,   // [0] frame_start
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [31:0]                         rsp_tdata,   // [7:0] census_code,
                                                                 // [19:8] center_row,
                                                                 // [29:20] center_col
   output logic                                     rsp_tlast,   // frame_last
   input  wire logic                                csr_we,
   input  wire logic [census_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  wire logic [census_pkg::CSR_W-1:0]        csr_wdata
);

   logic                             req_acc;
   logic                             rsp_acc;
   census_pkg::pos_type              cur_pos;
   census_pkg::dims_type             dims;

   logic                             s1_v_ff;
   logic [census_pkg::PIX_W-1:0]     s1_pix_ff;
   census_pkg::pos_type              s1_pos_ff;
   logic                             s1_byp_ff;
   logic [census_pkg::LINE_W-1:0]    s1_byp_data_ff;

   logic [census_pkg::LINE_W-1:0]    ram_rdata;
   logic [census_pkg::LINE_W-1:0]    entry;
   logic [census_pkg::LINE_W-1:0]    line_wdata;
   logic                             emit;
   census_pkg::result_type           result;
   census_pkg::result_type           head;
   logic [census_pkg::FIFO_CW-1:0]   fifo_cnt;

   // room for the word in stage one and the new word
   assign req_tready = (fifo_cnt == 3'd0) || (fifo_cnt == 3'd1) ||
                       ((fifo_cnt == 3'd2) && !s1_v_ff);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   // config registers and raster position
   census_pos u_pos (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_idx     (csr_idx),
      .csr_wdata   (csr_wdata),
      .accept      (req_acc),
      .frame_start (req_tuser),
      .cur_pos     (cur_pos),
      .dims        (dims)
   );

   // two rows above, one entry per column
   census_ram #(
      .WIDTH (census_pkg::LINE_W),
      .DEPTH (census_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_v_ff),
      .wr_addr (s1_pos_ff.col[census_pkg::LINE_AW-1:0]),
      .wr_data (line_wdata),
      .rd_en   (req_acc),
      .rd_addr (cur_pos.col[census_pkg::LINE_AW-1:0]),
      .rd_data (ram_rdata)
   );

   // stage one: the accepted word while its line entry is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pix_ff      <= req_tdata;
         s1_pos_ff      <= cur_pos;
         s1_byp_ff      <= s1_v_ff && (s1_pos_ff.col == cur_pos.col);
         s1_byp_data_ff <= line_wdata;
      end
   end

   // forward the entry written in the same cycle it was read
   assign entry = s1_byp_ff ? s1_byp_data_ff : ram_rdata;

   census_window u_window (
      .clock      (clock),
      .reset      (reset),
      .valid      (s1_v_ff),
      .pix        (s1_pix_ff),
      .entry      (entry),
      .pos        (s1_pos_ff),
      .dims       (dims),
      .line_wdata (line_wdata),
      .emit       (emit),
      .result     (result)
   );

   // result queue toward rsp
   census_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (emit),
      .wr_data  (result),
      .rd_en    (rsp_acc),
      .rd_valid (rsp_tvalid),
      .rd_data  (head),
      .count    (fifo_cnt)
   );

   assign rsp_tdata = {2'b00, head.col, head.row, head.code};
   assign rsp_tlast = head.last;

   // checks
   `CENSUS_ASSERT(a_queue_room, (fifo_cnt + {2'b00, s1_v_ff}) <= 3'd3)
   `CENSUS_ASSERT(a_col_in_frame, s1_v_ff |-> ({1'b0, s1_pos_ff.col} < dims.width))
   `CENSUS_ASSERT(a_center_inside, emit |-> (result.row != '0) && (result.col != '0))
   `CENSUS_ASSERT_ALWAYS(a_reset_empty, reset |=> !s1_v_ff && (fifo_cnt == 3'd0))

endmodule

`default_nettype wire
